>>> rtl/metp_pkg.sv
// Shared widths, fixed-point constants and the multiplier request type for the pixel engine.
`default_nettype none

package metp_pkg;

  // Data path widths
  localparam int unsigned DW        = 64;   // fixed-point word
  localparam int unsigned PW        = 128;  // full product
  localparam int unsigned HW        = 32;   // partial product operand
  localparam int unsigned FRAC_BITS = 60;   // fraction bits of the fixed-point word

  // Pixel index and iteration count widths
  localparam int unsigned MAX_DIM   = 4096;
  localparam int unsigned IDX_W     = 12;
  localparam int unsigned CNT_W     = 16;
  localparam int unsigned STEP_W    = 63;

  // Request from the sequencer to the shared multiplier
  typedef struct packed {
    logic          start;
    logic [DW-1:0] a;
    logic [DW-1:0] b;
  } mul_req_t;

endpackage

`default_nettype wire

>>> rtl/metp_mul.sv
// Shared 64x64 unsigned multiplier built from four 32x32 partial products, accumulated in turn.
`default_nettype none

module metp_mul (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire metp_pkg::mul_req_t         req_i,
  output logic                            done_o,
  output logic [metp_pkg::PW-1:0]         prod_o
);

  logic [metp_pkg::DW-1:0] a_q, b_q;
  logic [1:0]              phase_q;
  logic                    run_q;
  logic [metp_pkg::DW-1:0] pp_q;
  logic [1:0]              pp_sel_q;
  logic                    pp_vld_q;
  logic                    pp_last_q;
  logic [metp_pkg::PW-1:0] acc_q;
  logic                    done_q;

  logic [metp_pkg::HW-1:0] a_half, b_half;
  logic [metp_pkg::PW-1:0] pp_shifted;

  // Pick the operand halves for the current partial product
  assign a_half = phase_q[0] ? a_q[metp_pkg::DW-1:metp_pkg::HW] : a_q[metp_pkg::HW-1:0];
  assign b_half = phase_q[1] ? b_q[metp_pkg::DW-1:metp_pkg::HW] : b_q[metp_pkg::HW-1:0];

  // Align the registered partial product to its weight
  always_comb begin
    case (pp_sel_q)
      2'd0:    pp_shifted = {{metp_pkg::DW{1'b0}}, pp_q};
      2'd1,
      2'd2:    pp_shifted = {{metp_pkg::HW{1'b0}}, pp_q, {metp_pkg::HW{1'b0}}};
      2'd3:    pp_shifted = {pp_q, {metp_pkg::DW{1'b0}}};
      default: pp_shifted = '0;
    endcase
  end

  // Sequence control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= 2'd0;
      run_q     <= 1'b0;
      pp_vld_q  <= 1'b0;
      pp_last_q <= 1'b0;
      done_q    <= 1'b0;
    end else if (req_i.start) begin
      phase_q   <= 2'd0;
      run_q     <= 1'b1;
      pp_vld_q  <= 1'b0;
      pp_last_q <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      pp_vld_q  <= run_q;
      pp_last_q <= run_q && (phase_q == 2'd3);
      done_q    <= pp_vld_q && pp_last_q;
      if (run_q) begin
        phase_q <= phase_q + 2'd1;
        if (phase_q == 2'd3) begin
          run_q <= 1'b0;
        end
      end
    end
  end

  // Operands, partial product and accumulator
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      a_q   <= req_i.a;
      b_q   <= req_i.b;
      acc_q <= '0;
    end else begin
      if (run_q) begin
        pp_q     <= metp_pkg::DW'(a_half) * metp_pkg::DW'(b_half);
        pp_sel_q <= phase_q;
      end
      if (pp_vld_q) begin
        acc_q <= acc_q + pp_shifted;
      end
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

`default_nettype wire

>>> rtl/mandelbrot_escape_time_pixel.sv
// Top level of the escape-time pixel engine: configuration, sequencer and iteration data path.
`default_nettype none

// One pixel at a time. The index pair is mapped to c = origin + index * step on each axis, then
// z = z*z + c is iterated from zero in signed Q4.60 until |z|^2 reaches 4 or the count reaches
// max_iter; iter_count is the count, or 0 when the limit was hit. All products go through one
// shared 32x32 multiplier, four partial products per 64x64 product. Mapping takes two products
// and each iteration three (plus adds and the escape test), and a finished pixel may wait for
// the output to drain. The input is stalled while a pixel is in progress; a finished result
// sits in the output register while the next pixel is taken. The user must write registers
// only while the engine is idle; the block itself does not enforce this.
module mandelbrot_escape_time_pixel (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // pixel input
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [metp_pkg::IDX_W-1:0]    pixel_x_i,
  input  wire logic [metp_pkg::IDX_W-1:0]    pixel_y_i,
  // result output
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [metp_pkg::IDX_W-1:0]         out_x_o,
  output logic [metp_pkg::IDX_W-1:0]         out_y_o,
  output logic [metp_pkg::CNT_W-1:0]         iter_count_o,
  // register writes
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [2:0]                    cfg_index_i,
  input  wire logic [metp_pkg::DW-1:0]       cfg_data_i
);

  // Register indexes
  localparam logic [2:0] REG_ORIGIN_RE = 3'd0;
  localparam logic [2:0] REG_ORIGIN_IM = 3'd1;
  localparam logic [2:0] REG_STEP_X    = 3'd2;
  localparam logic [2:0] REG_STEP_Y    = 3'd3;
  localparam logic [2:0] REG_MAX_ITER  = 3'd4;

  // Sequencer states
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MAPX = 4'd1;
  localparam logic [3:0] S_WMX  = 4'd2;
  localparam logic [3:0] S_WMY  = 4'd3;
  localparam logic [3:0] S_WXY  = 4'd4;
  localparam logic [3:0] S_ADDY = 4'd5;
  localparam logic [3:0] S_WSQX = 4'd6;
  localparam logic [3:0] S_WSQY = 4'd7;
  localparam logic [3:0] S_TEST = 4'd8;
  localparam logic [3:0] S_DONE = 4'd9;

  localparam logic [metp_pkg::DW-1:0] SIGN   = {1'b1, {(metp_pkg::DW-1){1'b0}}};
  localparam logic [metp_pkg::DW-1:0] S64MAX = {1'b0, {(metp_pkg::DW-1){1'b1}}};
  localparam logic [metp_pkg::DW:0]   FOUR   = (metp_pkg::DW+1)'(4) << metp_pkg::FRAC_BITS;
  localparam logic [metp_pkg::IDX_W-1:0] IDX_LAST = metp_pkg::IDX_W'(metp_pkg::MAX_DIM - 1);
  localparam int unsigned IDX_PAD = metp_pkg::DW - metp_pkg::IDX_W;

  // Magnitude of a signed word as unsigned
  function automatic logic [metp_pkg::DW-1:0] mag(input logic [metp_pkg::DW-1:0] v);
    mag = v[metp_pkg::DW-1] ? (~v + metp_pkg::DW'(1)) : v;
  endfunction

  // Signed add, saturated to the 64-bit range
  function automatic logic [metp_pkg::DW-1:0] sat_add(input logic [metp_pkg::DW-1:0] a,
                                                      input logic [metp_pkg::DW-1:0] b);
    logic [metp_pkg::DW-1:0] s;
    s = a + b;
    if (a[metp_pkg::DW-1] == b[metp_pkg::DW-1] && s[metp_pkg::DW-1] != a[metp_pkg::DW-1]) begin
      s = a[metp_pkg::DW-1] ? SIGN : S64MAX;
    end
    sat_add = s;
  endfunction

  // Scale a magnitude product back to the word, truncate toward zero, apply sign, saturate
  function automatic logic [metp_pkg::DW-1:0] fix_fin(input logic [metp_pkg::PW-1:0] p,
                                                      input logic neg,
                                                      input logic dbl);
    logic [metp_pkg::PW-1:0] sh;
    logic                    ov;
    logic [metp_pkg::DW-1:0] q;
    logic [metp_pkg::DW-1:0] r;
    sh = dbl ? (p >> (metp_pkg::FRAC_BITS - 1)) : (p >> metp_pkg::FRAC_BITS);
    ov = |sh[metp_pkg::PW-1:metp_pkg::DW];
    q  = sh[metp_pkg::DW-1:0];
    if (ov) begin
      r = neg ? SIGN : S64MAX;
    end else if (neg) begin
      r = (q > SIGN) ? SIGN : (~q + metp_pkg::DW'(1));
    end else begin
      r = q[metp_pkg::DW-1] ? S64MAX : q;
    end
    fix_fin = r;
  endfunction

  // origin + index * step, saturated high
  function automatic logic [metp_pkg::DW-1:0] map_coord(input logic [metp_pkg::PW-1:0] p,
                                                        input logic [metp_pkg::DW-1:0] origin);
    logic                    ovf;
    logic [metp_pkg::DW:0]   s;
    ovf = |p[metp_pkg::PW-1:metp_pkg::DW];
    s   = {1'b0, origin ^ SIGN} + {1'b0, p[metp_pkg::DW-1:0]};
    map_coord = (ovf || s[metp_pkg::DW]) ? S64MAX : (s[metp_pkg::DW-1:0] ^ SIGN);
  endfunction

  // Configuration
  logic [metp_pkg::DW-1:0]     origin_re_q, origin_im_q;
  logic [metp_pkg::STEP_W-1:0] step_x_q, step_y_q;
  logic [metp_pkg::CNT_W-1:0]  max_iter_q;

  // Sequencer and data path
  logic [3:0]                  state_q, state_d;
  logic [metp_pkg::IDX_W-1:0]  px_q, py_q;
  logic [metp_pkg::DW-1:0]     cx_q, cy_q;
  logic [metp_pkg::DW-1:0]     zx_q, zy_q, zx2_q, zy2_q;
  logic [metp_pkg::DW-1:0]     diff_q, nx_q, fxy_q;
  logic [metp_pkg::CNT_W-1:0]  cnt_q;

  // Output register
  logic                        out_vld_q;
  logic [metp_pkg::IDX_W-1:0]  out_x_q, out_y_q;
  logic [metp_pkg::CNT_W-1:0]  out_cnt_q;

  metp_pkg::mul_req_t          mreq;
  logic                        mul_done;
  logic [metp_pkg::PW-1:0]     mul_prod;

  logic [metp_pkg::IDX_W-1:0]  idx_x, idx_y;
  logic [metp_pkg::DW-1:0]     zx_mag, zy_mag, nx_mag;
  logic [metp_pkg::DW:0]       mag2;
  logic                        more;
  logic                        out_free;

  metp_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mreq),
    .done_o (mul_done),
    .prod_o (mul_prod)
  );

  // Clamp indices to the frame
  assign idx_x = (px_q > IDX_LAST) ? IDX_LAST : px_q;
  assign idx_y = (py_q > IDX_LAST) ? IDX_LAST : py_q;

  assign zx_mag = mag(zx_q);
  assign zy_mag = mag(zy_q);
  assign nx_mag = mag(nx_q);

  // Escape test: keep going while below the limit and |z|^2 < 4
  assign mag2     = {1'b0, zx2_q} + {1'b0, zy2_q};
  assign more     = (cnt_q < max_iter_q) && (mag2 < FOUR);
  assign out_free = !out_vld_q || !out_stall_i;

  // Next state and multiplier requests
  always_comb begin
    state_d    = state_q;
    mreq.start = 1'b0;
    mreq.a     = zx_mag;
    mreq.b     = zy_mag;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_MAPX;
        end
      end
      S_MAPX: begin
        mreq.start = 1'b1;
        mreq.a     = {{IDX_PAD{1'b0}}, idx_x};
        mreq.b     = {1'b0, step_x_q};
        state_d    = S_WMX;
      end
      S_WMX: begin
        if (mul_done) begin
          mreq.start = 1'b1;
          mreq.a     = {{IDX_PAD{1'b0}}, idx_y};
          mreq.b     = {1'b0, step_y_q};
          state_d    = S_WMY;
        end
      end
      S_WMY: begin
        if (mul_done) begin
          mreq.start = 1'b1;
          state_d    = S_WXY;
        end
      end
      S_WXY: begin
        if (mul_done) begin
          state_d = S_ADDY;
        end
      end
      S_ADDY: begin
        mreq.start = 1'b1;
        mreq.a     = nx_mag;
        mreq.b     = nx_mag;
        state_d    = S_WSQX;
      end
      S_WSQX: begin
        if (mul_done) begin
          mreq.start = 1'b1;
          mreq.a     = zy_mag;
          mreq.b     = zy_mag;
          state_d    = S_WSQY;
        end
      end
      S_WSQY: begin
        if (mul_done) begin
          state_d = S_TEST;
        end
      end
      S_TEST: begin
        if (more) begin
          mreq.start = 1'b1;
          state_d    = S_WXY;
        end else begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control state, configuration and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_vld_q   <= 1'b0;
      origin_re_q <= '0;
      origin_im_q <= '0;
      step_x_q    <= '0;
      step_y_q    <= '0;
      max_iter_q  <= metp_pkg::CNT_W'(1024);
    end else begin
      state_q <= state_d;
      if (state_q == S_DONE && out_free) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
      if (cfg_valid_i) begin
        case (cfg_index_i)
          REG_ORIGIN_RE: origin_re_q <= cfg_data_i;
          REG_ORIGIN_IM: origin_im_q <= cfg_data_i;
          REG_STEP_X:    step_x_q    <= cfg_data_i[metp_pkg::STEP_W-1:0];
          REG_STEP_Y:    step_y_q    <= cfg_data_i[metp_pkg::STEP_W-1:0];
          REG_MAX_ITER:  max_iter_q  <= cfg_data_i[metp_pkg::CNT_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Iteration data path
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          px_q  <= pixel_x_i;
          py_q  <= pixel_y_i;
          zx_q  <= '0;
          zy_q  <= '0;
          zx2_q <= '0;
          zy2_q <= '0;
          cnt_q <= '0;
        end
      end
      S_WMX: begin
        if (mul_done) begin
          cx_q <= map_coord(mul_prod, origin_re_q);
        end
      end
      S_WMY: begin
        if (mul_done) begin
          cy_q   <= map_coord(mul_prod, origin_im_q);
          diff_q <= zx2_q - zy2_q;
        end
      end
      S_WXY: begin
        nx_q <= sat_add(diff_q, cx_q);
        if (mul_done) begin
          fxy_q <= fix_fin(mul_prod, zx_q[metp_pkg::DW-1] ^ zy_q[metp_pkg::DW-1], 1'b1);
        end
      end
      S_ADDY: begin
        zy_q <= sat_add(fxy_q, cy_q);
        zx_q <= nx_q;
      end
      S_WSQX: begin
        if (mul_done) begin
          zx2_q <= fix_fin(mul_prod, 1'b0, 1'b0);
        end
      end
      S_WSQY: begin
        if (mul_done) begin
          zy2_q <= fix_fin(mul_prod, 1'b0, 1'b0);
          cnt_q <= cnt_q + metp_pkg::CNT_W'(1);
        end
      end
      S_TEST: begin
        diff_q <= zx2_q - zy2_q;
      end
      S_DONE: begin
        if (out_free) begin
          out_x_q   <= px_q;
          out_y_q   <= py_q;
          out_cnt_q <= (cnt_q != max_iter_q) ? cnt_q : '0;
        end
      end
      default: ;
    endcase
  end

  assign in_stall_o   = (state_q != S_IDLE);
  assign out_valid_o  = out_vld_q;
  assign out_x_o      = out_x_q;
  assign out_y_o      = out_y_q;
  assign iter_count_o = out_cnt_q;
  assign cfg_ready_o  = 1'b1;

  // Multiplier results arrive only while the sequencer waits for one
  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_done |-> (state_q == S_WMX || state_q == S_WMY || state_q == S_WXY ||
                  state_q == S_WSQX || state_q == S_WSQY))
    else $error("multiplier result outside a wait state");

  // The escape test sees at least one iteration and, unless the limit is zero, never more than the limit
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_TEST) |-> (cnt_q != '0 && (cnt_q <= max_iter_q || max_iter_q == '0)))
    else $error("iteration count out of range at escape test");

  // Squares are never negative
  a_sq_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_TEST) |-> (!zx2_q[metp_pkg::DW-1] && !zy2_q[metp_pkg::DW-1]))
    else $error("negative square");

  // A new result is loaded only on leaving the done state
  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> ($past(state_q) == S_DONE))
    else $error("result raised outside the done state");

endmodule

`default_nettype wire

>>> dv/mandelbrot_escape_time_pixel_tb.sv
// Self-checking testbench for the Mandelbrot escape-time pixel engine.
`timescale 1ns / 1ps

module mandelbrot_escape_time_pixel_tb;
  import metp_pkg::*;

  localparam int unsigned RUN_LIMIT   = 3_000_000;
  localparam int unsigned TAIL_CYCLES = 64;
  localparam int unsigned IDLE_PCT    = 11;
  localparam int unsigned RAND_ITEMS  = 560;
  localparam int unsigned LIMIT_HI    = 40;

  localparam logic signed [DW-1:0] S64_MAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] S64_MIN = {1'b1, {(DW-1){1'b0}}};
  localparam longint              ONE_Q   = longint'(1) <<< FRAC_BITS;
  localparam logic [DW:0]         ESCAPE_R2 = (DW+1)'(4) << FRAC_BITS;

  typedef enum logic [2:0] {
    REG_ORIGIN_RE, REG_ORIGIN_IM, REG_STEP_X, REG_STEP_Y, REG_MAX_ITER,
    REG_SPARE_5, REG_SPARE_6, REG_SPARE_7
  } reg_idx_e;

  typedef enum logic {ENTRY_PIXEL, ENTRY_WRITE} entry_kind_e;

  typedef struct packed {
    entry_kind_e      kind;
    logic             calm;
    logic [IDX_W-1:0] x;
    logic [IDX_W-1:0] y;
    reg_idx_e         idx;
    logic [DW-1:0]    data;
  } feed_entry_t;

  typedef struct packed {
    logic [IDX_W-1:0] x;
    logic [IDX_W-1:0] y;
    logic [CNT_W-1:0] count;
  } pixel_count_t;

  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             in_valid_i  = 1'b0;
  logic [IDX_W-1:0] pixel_x_i   = '0;
  logic [IDX_W-1:0] pixel_y_i   = '0;
  logic             out_stall_i = 1'b0;
  logic             cfg_valid_i = 1'b0;
  logic [2:0]       cfg_index_i = '0;
  logic [DW-1:0]    cfg_data_i  = '0;
  logic             in_stall_o;
  logic             out_valid_o;
  logic             cfg_ready_o;
  logic [IDX_W-1:0] out_x_o;
  logic [IDX_W-1:0] out_y_o;
  logic [CNT_W-1:0] iter_count_o;

  // Shadow copy of the engine's registers
  logic signed [DW-1:0] view_re    = '0;
  logic signed [DW-1:0] view_im    = '0;
  logic [STEP_W-1:0]    pitch_x    = '0;
  logic [STEP_W-1:0]    pitch_y    = '0;
  logic [CNT_W-1:0]     iter_limit = 16'd1024;

  feed_entry_t  pixel_feed[$];
  pixel_count_t due_counts[$];

  logic        in_taken  = 1'b0;
  logic        cfg_taken = 1'b0;
  logic        calm      = 1'b0;
  logic        calm_fill = 1'b0;
  int unsigned fail_cnt  = 0;
  int unsigned cycle_cnt = 0;

  mandelbrot_escape_time_pixel dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .pixel_x_i    (pixel_x_i),
    .pixel_y_i    (pixel_y_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_x_o      (out_x_o),
    .out_y_o      (out_y_o),
    .iter_count_o (iter_count_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
  end

  // Clamp a wide signed value to the 64-bit range
  function automatic logic signed [DW-1:0] clamp64(logic signed [DW+65:0] v);
    if (v > S64_MAX) return S64_MAX;
    if (v < S64_MIN) return S64_MIN;
    return v[DW-1:0];
  endfunction

  // Full-width product, shifted down with truncation toward zero
  function automatic logic signed [DW-1:0] fixed_mul(logic signed [DW-1:0] a,
                                                     logic signed [DW-1:0] b,
                                                     int unsigned sh);
    logic signed [DW+65:0] p;
    logic signed [DW+65:0] mag;
    p   = a * b;
    mag = (p < 0) ? -p : p;
    mag = mag >>> sh;
    return clamp64((p < 0) ? -mag : mag);
  endfunction

  function automatic logic signed [DW-1:0] sat_sum(logic signed [DW-1:0] a,
                                                   logic signed [DW-1:0] b);
    logic signed [DW+65:0] s;
    s = a + b;
    return clamp64(s);
  endfunction

  // Map a pixel index onto one axis of the complex plane
  function automatic logic signed [DW-1:0] point_coord(logic signed [DW-1:0] origin,
                                                       logic [IDX_W-1:0] idx,
                                                       logic [STEP_W-1:0] pitch);
    logic signed [DW+65:0] s;
    s = origin + $signed({1'b0, idx}) * $signed({1'b0, pitch});
    return clamp64(s);
  endfunction

  // Iterate z = z*z + c until escape or the limit; the limit reports as zero
  function automatic logic [CNT_W-1:0] escape_iters(logic signed [DW-1:0] cx,
                                                    logic signed [DW-1:0] cy,
                                                    logic [CNT_W-1:0] limit);
    logic signed [DW-1:0] zx;
    logic signed [DW-1:0] zy;
    logic signed [DW-1:0] zx2;
    logic signed [DW-1:0] zy2;
    logic signed [DW-1:0] nx;
    logic [DW:0]          mag2;
    int unsigned          cnt;
    zx  = '0;
    zy  = '0;
    zx2 = '0;
    zy2 = '0;
    cnt = 0;
    do begin
      nx   = sat_sum(zx2 - zy2, cx);
      zy   = sat_sum(fixed_mul(zx, zy, FRAC_BITS - 1), cy);
      zx   = nx;
      zx2  = fixed_mul(zx, zx, FRAC_BITS);
      zy2  = fixed_mul(zy, zy, FRAC_BITS);
      cnt++;
      mag2 = {1'b0, zx2} + {1'b0, zy2};
    end while (cnt < limit && mag2 < ESCAPE_R2);
    return (cnt != limit) ? cnt[CNT_W-1:0] : '0;
  endfunction

  function automatic logic [DW-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic note_field(string what, int unsigned want, int unsigned got);
    if (want !== got) begin
      fail_cnt++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
    end
  endtask

  task automatic push_write(reg_idx_e idx, logic [DW-1:0] data);
    feed_entry_t e;
    e      = '0;
    e.kind = ENTRY_WRITE;
    e.calm = calm_fill;
    e.idx  = idx;
    e.data = data;
    pixel_feed.push_back(e);
  endtask

  task automatic push_pixel(logic [IDX_W-1:0] x, logic [IDX_W-1:0] y);
    feed_entry_t e;
    e      = '0;
    e.kind = ENTRY_PIXEL;
    e.calm = calm_fill;
    e.x    = x;
    e.y    = y;
    pixel_feed.push_back(e);
  endtask

  // Sample handshakes, update the shadow registers and check results
  always @(posedge clk_i) begin : monitor
    pixel_count_t         got;
    pixel_count_t         want;
    logic signed [DW-1:0] cx;
    logic signed [DW-1:0] cy;
    if (rst_ni) begin
      in_taken  <= in_valid_i && !in_stall_o;
      cfg_taken <= cfg_valid_i && cfg_ready_o;

      if (out_valid_o && !out_stall_i) begin
        got.x     = out_x_o;
        got.y     = out_y_o;
        got.count = iter_count_o;
        if (due_counts.size() == 0) begin
          fail_cnt++;
          $display("%0t: unexpected result, expected none, actual x=%0d y=%0d count=%0d",
                   $time, got.x, got.y, got.count);
        end else begin
          want = due_counts.pop_front();
          note_field("out_x", 32'(want.x), 32'(got.x));
          note_field("out_y", 32'(want.y), 32'(got.y));
          note_field("iter_count", 32'(want.count), 32'(got.count));
        end
      end

      if (cfg_valid_i && cfg_ready_o) begin
        case (reg_idx_e'(cfg_index_i))
          REG_ORIGIN_RE: view_re    = cfg_data_i;
          REG_ORIGIN_IM: view_im    = cfg_data_i;
          REG_STEP_X:    pitch_x    = cfg_data_i[STEP_W-1:0];
          REG_STEP_Y:    pitch_y    = cfg_data_i[STEP_W-1:0];
          REG_MAX_ITER:  iter_limit = cfg_data_i[CNT_W-1:0];
          default: ;  // spare indexes leave the registers alone
        endcase
      end

      if (in_valid_i && !in_stall_o) begin
        cx         = point_coord(view_re, pixel_x_i, pitch_x);
        cy         = point_coord(view_im, pixel_y_i, pitch_y);
        want.x     = pixel_x_i;
        want.y     = pixel_y_i;
        want.count = escape_iters(cx, cy, iter_limit);
        due_counts.push_back(want);
      end
    end
  end

  // Present items on the falling edge; hold each until it is taken
  always @(negedge clk_i) begin : driver
    logic        iv;
    logic        cv;
    feed_entry_t nxt;
    if (rst_ni) begin
      iv = in_valid_i && !in_taken;
      cv = cfg_valid_i && !cfg_taken;
      if (!iv && !cv && pixel_feed.size() != 0) begin
        nxt  = pixel_feed[0];
        calm = nxt.calm;
        if (nxt.kind == ENTRY_WRITE) begin
          // write registers only once every result has drained
          if (due_counts.size() == 0) begin
            cv          = 1'b1;
            cfg_index_i <= nxt.idx;
            cfg_data_i  <= nxt.data;
            void'(pixel_feed.pop_front());
          end
        end else if (calm || $urandom_range(0, 99) >= IDLE_PCT) begin
          iv        = 1'b1;
          pixel_x_i <= nxt.x;
          pixel_y_i <= nxt.y;
          void'(pixel_feed.pop_front());
        end
      end
      in_valid_i  <= iv;
      cfg_valid_i <= cv;
      out_stall_i <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
    end
  end

  // Give up on a hung run
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == RUN_LIMIT) begin
      $display("%0t: run limit reached with %0d results outstanding", $time, due_counts.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin : stimulus
    logic [DW-1:0] word;
    longint        ore;
    longint        oim;
    logic [DW-1:0] sx;
    logic [DW-1:0] sy;
    int unsigned   n_rand;
    int unsigned   phase_len;
    int unsigned   phase;

    // Reset values: every pixel maps to zero and runs to the limit
    push_pixel(12'hFFF, 12'h000);

    // Limit of zero in the low half, junk above it
    word       = rand64();
    word[15:0] = '0;
    push_write(REG_MAX_ITER, word);
    push_pixel(12'h000, 12'h000);
    push_pixel(12'hFFF, 12'hFFF);

    // Extreme origins and steps: coordinates saturate, escape at once
    push_write(REG_ORIGIN_RE, S64_MAX);
    push_write(REG_ORIGIN_IM, S64_MIN);
    push_write(REG_STEP_X, '1);
    push_write(REG_STEP_Y, S64_MAX);
    word       = rand64();
    word[15:0] = '1;
    push_write(REG_MAX_ITER, word);
    push_pixel(12'h000, 12'h000);
    push_pixel(12'hFFF, 12'hFFF);
    push_pixel(12'h000, 12'hFFF);
    push_pixel(12'hFFF, 12'h000);

    // Spare indexes must not disturb anything
    push_write(REG_SPARE_5, rand64());
    push_write(REG_SPARE_6, rand64());
    push_write(REG_SPARE_7, rand64());
    push_pixel(IDX_W'($urandom_range(0, MAX_DIM - 1)), IDX_W'($urandom_range(0, MAX_DIM - 1)));

    // Classic full view, both inside and outside points
    push_write(REG_ORIGIN_RE, -2 * ONE_Q);
    push_write(REG_ORIGIN_IM, -(ONE_Q / 2) * 3);
    push_write(REG_STEP_X, (ONE_Q * 3) / MAX_DIM);
    push_write(REG_STEP_Y, (ONE_Q * 3) / MAX_DIM);
    push_write(REG_MAX_ITER, DW'(64));
    push_pixel(12'd0, 12'd0);
    push_pixel(12'd4095, 12'd4095);
    push_pixel(12'd2730, 12'd2048);
    push_pixel(12'd1365, 12'd2048);
    push_pixel(12'd2048, 12'd0);
    push_pixel(12'd4095, 12'd2048);
    push_pixel(12'd3413, 12'd2048);
    push_pixel(12'd2048, 12'd2900);

    // Limit of one: every point reports as inside
    push_write(REG_MAX_ITER, DW'(1));
    push_pixel(IDX_W'($urandom_range(0, MAX_DIM - 1)), IDX_W'($urandom_range(0, MAX_DIM - 1)));
    push_pixel(IDX_W'($urandom_range(0, MAX_DIM - 1)), IDX_W'($urandom_range(0, MAX_DIM - 1)));

    // Random phases: mostly views near the set, some wild settings
    n_rand = 0;
    phase  = 0;
    while (n_rand < RAND_ITEMS) begin
      calm_fill = (phase == 3);
      if ($urandom_range(0, 9) < 7) begin
        ore = -(ONE_Q / 4) * 9 + longint'($urandom_range(0, 1 << 20)) * ((ONE_Q / 4) * 11 >>> 20)
              + longint'($urandom);
        oim = -(ONE_Q / 4) * 5 + longint'($urandom_range(0, 1 << 20)) * ((ONE_Q / 2) * 5 >>> 20)
              + longint'($urandom);
        sx  = rand64() >> $urandom_range(13, 40);
        sy  = ($urandom_range(0, 1) == 0) ? sx : rand64() >> $urandom_range(13, 40);
      end else begin
        ore = rand64();
        oim = rand64();
        sx  = rand64() >> $urandom_range(0, 63);
        sy  = rand64() >> $urandom_range(0, 63);
      end
      push_write(REG_ORIGIN_RE, ore);
      push_write(REG_ORIGIN_IM, oim);
      push_write(REG_STEP_X, sx);
      push_write(REG_STEP_Y, sy);
      word       = rand64();
      word[15:0] = CNT_W'($urandom_range(0, LIMIT_HI));
      push_write(REG_MAX_ITER, word);
      if ($urandom_range(0, 3) == 0)
        push_write(reg_idx_e'($urandom_range(REG_SPARE_5, REG_SPARE_7)), rand64());
      phase_len = $urandom_range(25, 60);
      repeat (phase_len)
        push_pixel(IDX_W'($urandom_range(0, MAX_DIM - 1)),
                   IDX_W'($urandom_range(0, MAX_DIM - 1)));
      n_rand += phase_len;
      phase++;
    end

    // Drain: all items taken, all results in, then a short tail
    while (pixel_feed.size() != 0 || in_valid_i || cfg_valid_i) @(posedge clk_i);
    while (due_counts.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
